// ===== hw/rtl/rhc_pkg.sv =====
// ----------------------------------------------------------------------------
// rhc_pkg
// Types and constants shared by the RGB to HSV converter modules.
// ----------------------------------------------------------------------------
package rhc_pkg;

    localparam int CHANNEL_BITS      = 8;
    localparam int HUE_FRACTION_BITS = 6;

    // Quotient bits per division; covers both the saturation and hue quotients
    localparam int QUO_W = 16;
    localparam int NUM_W = CHANNEL_BITS + QUO_W;
    localparam int HUE_W = 9 + HUE_FRACTION_BITS;
    localparam int SAT_W = 16;

    localparam int HUE_SEXTANT = 60 << HUE_FRACTION_BITS;
    localparam int HUE_FULL    = 360 << HUE_FRACTION_BITS;
    localparam int SAT_FULL    = 65535;

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [HUE_W-1:0]        hue_angle;
        logic [SAT_W-1:0]        saturation_level;
        logic [CHANNEL_BITS-1:0] brightness_level;
    } t_hsv;

    // One restoring divider lane: divisor, partial remainder and a word that
    // holds the unused dividend bits on top and the quotient bits below.
    typedef struct packed {
        logic [CHANNEL_BITS-1:0] den;
        logic [CHANNEL_BITS-1:0] rem;
        logic [QUO_W-1:0]        nq;
    } t_div_lane;

    typedef struct packed {
        t_div_lane sat;
        t_div_lane hue;
        t_sector   sector;
        logic      hue_neg;
        logic      grey;
        logic      black;
    } t_cell_data;

endpackage

// ===== hw/rtl/rhc_div_cell.sv =====
// ----------------------------------------------------------------------------
// rhc_div_cell
// One pipeline cell: one restoring division step on both divider lanes.
// ----------------------------------------------------------------------------
module rhc_div_cell
    import rhc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  logic       i_valid,
    input  t_cell_data i_data,
    output logic       o_valid,
    output t_cell_data o_data
);

    logic       r_valid;
    t_cell_data r_data;
    t_cell_data n_data;

    function automatic t_div_lane div_step(input t_div_lane l);
        logic [CHANNEL_BITS:0] trial;
        logic [CHANNEL_BITS:0] diff;
        logic                  ge;
        t_div_lane             res;
        trial = {l.rem, l.nq[QUO_W-1]};
        diff  = trial - {1'b0, l.den};
        ge    = (trial >= {1'b0, l.den});
        res.den = l.den;
        res.rem = ge ? diff[CHANNEL_BITS-1:0] : trial[CHANNEL_BITS-1:0];
        res.nq  = {l.nq[QUO_W-2:0], ge};
        return res;
    endfunction

    always_comb begin
        n_data     = i_data;
        n_data.sat = div_step(i_data.sat);
        n_data.hue = div_step(i_data.hue);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hw/rtl/rhc_div_chain.sv =====
// ----------------------------------------------------------------------------
// rhc_div_chain
// Row of division cells, one quotient bit per cell, with bubble collapsing.
// ----------------------------------------------------------------------------
module rhc_div_chain
    import rhc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_cell_data i_data,
    output logic       o_adv,
    output logic       o_valid,
    output t_cell_data o_data,
    input  logic       i_adv
);

    logic       vld [QUO_W+1];
    t_cell_data dat [QUO_W+1];
    logic       adv [QUO_W+1];

    assign vld[0]     = i_valid;
    assign dat[0]     = i_data;
    assign adv[QUO_W] = i_adv;

    for (genvar k = 0; k < QUO_W; k++) begin : g_cell
        // a cell loads when empty or when its contents move on
        assign adv[k] = !vld[k+1] || adv[k+1];

        rhc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv[k]),
            .i_valid (vld[k]),
            .i_data  (dat[k]),
            .o_valid (vld[k+1]),
            .o_data  (dat[k+1])
        );
    end

    assign o_adv   = adv[0];
    assign o_valid = vld[QUO_W];
    assign o_data  = dat[QUO_W];

endmodule

// ===== hw/rtl/rgb_to_hsv_converter.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Converts one 8-bit RGB pixel into hue, saturation and brightness.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  : i_valid / o_stall / i_data (red, green, blue). An item is
//                    taken at a clock edge with i_valid high and o_stall low.
//   Output channel : o_valid / i_stall / o_data (hue_angle, saturation_level,
//                    brightness_level). An item leaves at an edge with o_valid
//                    high and i_stall low. One result per pixel, in order.
//   Stages         : 18 register stages: one front stage (max/min, sector,
//                    dividends), 16 division cells (one quotient bit of both
//                    divisions per cell) and the output register that applies
//                    the floor and sector offset.
//   Throughput     : one pixel per clock while i_stall is low; the 16-cell
//                    divider row is fully pipelined.
//   Stall          : while i_stall holds the output, earlier stages keep
//                    filling their empty slots, so o_stall rises only once
//                    every stage holds an item.
//   Reset          : i_rst_n (synchronous, active low) empties all stages;
//                    no item is in flight afterwards.
//   Hue is in 1/64 degree units, 0 for grey pixels; saturation is
//   floor(delta*65535/max), 0 for black.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter
    import rhc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_stall,
    input  t_pixel i_data,
    output logic   o_valid,
    input  logic   i_stall,
    output t_hsv   o_data
);

    // ---------------- front stage ----------------
    logic [CHANNEL_BITS-1:0] mx;
    logic [CHANNEL_BITS-1:0] mn;
    logic [CHANNEL_BITS-1:0] delta;
    logic [CHANNEL_BITS-1:0] pos_a;
    logic [CHANNEL_BITS-1:0] pos_b;
    logic [CHANNEL_BITS-1:0] mag;
    logic [NUM_W-1:0]        sat_num;
    logic [NUM_W-1:0]        hue_num;
    t_sector                 sector;
    t_cell_data              n_front;

    logic       r_f_vld;
    t_cell_data r_front;
    logic       f_adv;

    logic       chain_adv;
    logic       chain_vld;
    t_cell_data chain_dat;
    logic       out_adv;

    always_comb begin
        // ties go to red, then green
        if (i_data.red >= i_data.green && i_data.red >= i_data.blue) begin
            sector = SEC_RED;
            mx     = i_data.red;
            pos_a  = i_data.green;
            pos_b  = i_data.blue;
        end else if (i_data.green >= i_data.blue) begin
            sector = SEC_GREEN;
            mx     = i_data.green;
            pos_a  = i_data.blue;
            pos_b  = i_data.red;
        end else begin
            sector = SEC_BLUE;
            mx     = i_data.blue;
            pos_a  = i_data.red;
            pos_b  = i_data.green;
        end

        mn = i_data.red;
        if (i_data.green < mn) mn = i_data.green;
        if (i_data.blue < mn)  mn = i_data.blue;
        delta = mx - mn;

        // signed sector difference pos_a - pos_b, split into sign and magnitude
        mag = (pos_a >= pos_b) ? (pos_a - pos_b) : (pos_b - pos_a);

        // delta * 65535 as a shift and subtract
        sat_num = {delta, {QUO_W{1'b0}}} - NUM_W'(delta);
        hue_num = NUM_W'(mag) * NUM_W'(HUE_SEXTANT);

        n_front.sat.den = mx;
        n_front.sat.rem = sat_num[NUM_W-1:QUO_W];
        n_front.sat.nq  = sat_num[QUO_W-1:0];
        n_front.hue.den = delta;
        n_front.hue.rem = hue_num[NUM_W-1:QUO_W];
        n_front.hue.nq  = hue_num[QUO_W-1:0];
        n_front.sector  = sector;
        n_front.hue_neg = (pos_a < pos_b);
        n_front.grey    = (delta == '0);
        n_front.black   = (mx == '0);
    end

    assign f_adv   = !r_f_vld || chain_adv;
    assign o_stall = !f_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (f_adv) begin
            r_f_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_adv) begin
            r_front <= n_front;
        end
    end

    // ---------------- divider row ----------------
    rhc_div_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_f_vld),
        .i_data  (r_front),
        .o_adv   (chain_adv),
        .o_valid (chain_vld),
        .o_data  (chain_dat),
        .i_adv   (out_adv)
    );

    // ---------------- finish and output register ----------------
    logic [QUO_W-1:0] hue_q;
    logic [QUO_W-1:0] hue_ceil;
    logic [HUE_W:0]   hue_base;
    logic [HUE_W:0]   hue_sum;
    t_hsv             n_out;
    logic             r_o_vld;
    t_hsv             r_out;

    assign out_adv = !r_o_vld || !i_stall;

    always_comb begin
        hue_q    = chain_dat.hue.nq;
        // floor of a negative quotient is minus the ceiling of its magnitude
        hue_ceil = hue_q + QUO_W'(chain_dat.hue.rem != '0);

        case (chain_dat.sector)
            SEC_RED:   hue_base = chain_dat.hue_neg ? (HUE_W+1)'(HUE_FULL) : '0;
            SEC_GREEN: hue_base = (HUE_W+1)'(2 * HUE_SEXTANT);
            SEC_BLUE:  hue_base = (HUE_W+1)'(4 * HUE_SEXTANT);
            default:   hue_base = '0;
        endcase

        if (chain_dat.hue_neg) begin
            hue_sum = hue_base - (HUE_W+1)'(hue_ceil);
        end else begin
            hue_sum = hue_base + (HUE_W+1)'(hue_q);
        end

        n_out.hue_angle        = chain_dat.grey ? '0 : hue_sum[HUE_W-1:0];
        n_out.saturation_level = chain_dat.black ? '0 : chain_dat.sat.nq[SAT_W-1:0];
        n_out.brightness_level = chain_dat.sat.den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (out_adv) begin
            r_o_vld <= chain_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_o_vld;
    assign o_data  = r_out;

endmodule

// ===== sim/rgb_to_hsv_converter_tb.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_tb
// Self-checking testbench for the RGB to HSV converter.
// ----------------------------------------------------------------------------
// A queue of pending pixels feeds a falling-edge driver. The monitor samples
// both channels at the rising edge. For each pixel the block accepts, it
// works out the expected hue, saturation and brightness and queues the
// result. Each result the block sends is checked field by field against the
// oldest queued result. Both sides idle at random. One phase holds the output
// for a long stretch while the sender keeps offering pixels, so the block
// fills up and stalls its input.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rhc_pkg::*;

    // ------------------------------------------------------------------------
    // DUT signals; every input is known from time zero
    // ------------------------------------------------------------------------
    logic   i_clk   = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_valid = 1'b0;
    logic   o_stall;
    t_pixel i_data  = '0;
    logic   o_valid;
    logic   i_stall = 1'b0;
    t_hsv   o_data;

    rgb_to_hsv_converter i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    initial forever #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Shared state
    // ------------------------------------------------------------------------
    t_pixel pending_pixels[$];   // pixels waiting to be driven
    t_hsv   expected_hsv_q[$];   // results owed by the block, oldest first
    int     mismatch_count = 0;
    int     results_seen   = 0;

    logic   pixel_taken   = 1'b0; // an item went in at the last rising edge
    int     tx_gap_left   = 0;
    int     rx_stall_left = 0;
    logic   tx_burst      = 1'b0; // sender offers back to back
    logic   rx_burst      = 1'b0; // receiver never stalls on its own
    logic   long_hold_req = 1'b0; // ask the receiver for one long hold
    logic   long_hold_run = 1'b0;

    t_pixel next_pixel;
    int     rx_next_stall;
    int     tx_pick;
    int     rx_pick;
    t_hsv   want_hsv;

    // ------------------------------------------------------------------------
    // Expected conversion of one pixel.
    // Brightness is the top channel, saturation is floor(delta*65535/max).
    // Hue picks the sector red, then green, then blue on ties, floors the
    // sector quotient toward minus infinity and wraps negative hue by 360.
    // Grey pixels get hue 0; black pixels get saturation 0 too.
    // ------------------------------------------------------------------------
    function automatic t_hsv compute_hsv(input t_pixel px);
        int   r, g, b;
        int   top, low, delta;
        int   num, quo, offset, hue, sat;
        t_hsv res;
        r = px.red;
        g = px.green;
        b = px.blue;
        top = r;
        low = r;
        if (g > top) top = g;
        if (b > top) top = b;
        if (g < low) low = g;
        if (b < low) low = b;
        delta = top - low;

        sat = (top != 0) ? (delta * SAT_FULL) / top : 0;

        hue = 0;
        if (delta != 0) begin
            if (top == r) begin
                num    = HUE_SEXTANT * (g - b);
                offset = 0;
            end else if (top == g) begin
                num    = HUE_SEXTANT * (b - r);
                offset = 2 * HUE_SEXTANT;
            end else begin
                num    = HUE_SEXTANT * (r - g);
                offset = 4 * HUE_SEXTANT;
            end
            // integer divide truncates; pull negative remainders down
            quo = num / delta;
            if (num < 0 && (num % delta) != 0) quo = quo - 1;
            hue = quo + offset;
            if (hue < 0) hue = hue + HUE_FULL;
        end

        res.hue_angle        = hue[HUE_W-1:0];
        res.saturation_level = sat[SAT_W-1:0];
        res.brightness_level = top[CHANNEL_BITS-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH: %s", msg);
    endtask

    // ------------------------------------------------------------------------
    // Sender: falling-edge driver. A new item (or a gap) is chosen only when
    // nothing is on offer or the offered item was just taken, so a stalled
    // payload never changes.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || pixel_taken) begin
            if (tx_gap_left > 0) begin
                tx_gap_left--;
                i_valid <= 1'b0;
            end else if (pending_pixels.size() > 0) begin
                next_pixel = pending_pixels.pop_front();
                i_data  <= next_pixel;
                i_valid <= 1'b1;
                // gap after this item: mostly none or short, rarely long
                if (tx_burst) begin
                    tx_gap_left = 0;
                end else begin
                    tx_pick = $urandom_range(0, 99);
                    if (tx_pick < 50) begin
                        tx_gap_left = 0;
                    end else if (tx_pick < 90) begin
                        tx_gap_left = $urandom_range(1, 3);
                    end else if (tx_pick < 98) begin
                        tx_gap_left = $urandom_range(4, 12);
                    end else begin
                        tx_gap_left = $urandom_range(20, 60);
                    end
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall pattern, also changed at the falling edge.
    // The long hold is counted here, in cycles, independent of the sender.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (long_hold_req && !long_hold_run) begin
                long_hold_run = 1'b1;
                rx_stall_left = 100;
            end
            if (rx_stall_left > 0) begin
                rx_stall_left--;
                i_stall <= 1'b1;
            end else begin
                rx_next_stall = 0;
                if (!rx_burst && $urandom_range(0, 99) < 25) begin
                    rx_pick = $urandom_range(0, 99);
                    if (rx_pick < 80) begin
                        rx_next_stall = $urandom_range(1, 3);
                    end else if (rx_pick < 97) begin
                        rx_next_stall = $urandom_range(4, 12);
                    end else begin
                        rx_next_stall = $urandom_range(20, 50);
                    end
                end
                rx_stall_left = (rx_next_stall > 0) ? rx_next_stall - 1 : 0;
                i_stall <= (rx_next_stall > 0);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: both handshakes sampled at the rising edge. Expectations are
    // made when the block accepts a pixel, and consumed in order.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pixel_taken <= 1'b0;
        end else begin
            pixel_taken <= i_valid && !o_stall;
            if (i_valid && !o_stall) expected_hsv_q.push_back(compute_hsv(i_data));

            if (o_valid && !i_stall) begin
                if (expected_hsv_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none expected",
                                              results_seen));
                end else begin
                    want_hsv = expected_hsv_q.pop_front();
                    if (o_data.hue_angle !== want_hsv.hue_angle)
                        report_mismatch($sformatf("result %0d hue_angle %0d, expected %0d",
                            results_seen, o_data.hue_angle, want_hsv.hue_angle));
                    if (o_data.saturation_level !== want_hsv.saturation_level)
                        report_mismatch($sformatf(
                            "result %0d saturation_level %0d, expected %0d",
                            results_seen, o_data.saturation_level,
                            want_hsv.saturation_level));
                    if (o_data.brightness_level !== want_hsv.brightness_level)
                        report_mismatch($sformatf(
                            "result %0d brightness_level %0d, expected %0d",
                            results_seen, o_data.brightness_level,
                            want_hsv.brightness_level));
                end
                results_seen++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_pixel(input int r, input int g, input int b);
        t_pixel px;
        px.red   = r[CHANNEL_BITS-1:0];
        px.green = g[CHANNEL_BITS-1:0];
        px.blue  = b[CHANNEL_BITS-1:0];
        pending_pixels.push_back(px);
    endtask

    // Random pixel, shaped so that ties, near-grey and extreme channels show
    // up far more often than uniform values would give them.
    task automatic push_random_pixel();
        int m, lo, base;
        m = $urandom_range(1, 255);
        lo = $urandom_range(0, m);
        base = $urandom_range(0, 255);
        case ($urandom_range(0, 9))
            4: begin
                // two channels share the maximum
                case ($urandom_range(0, 2))
                    0:       push_pixel(m, m, lo);
                    1:       push_pixel(m, lo, m);
                    default: push_pixel(lo, m, m);
                endcase
            end
            5: begin
                // nearly grey: tiny delta
                push_pixel(base,
                           (base + $urandom_range(0, 2)) % 256,
                           (base + 256 - $urandom_range(0, 2)) % 256);
            end
            6: begin
                push_pixel($urandom_range(0, 1) ? 255 : $urandom_range(0, 1),
                           $urandom_range(0, 1) ? 255 : $urandom_range(0, 1),
                           $urandom_range(0, 1) ? 0 : $urandom_range(254, 255));
            end
            7:       push_pixel(base, base, base);
            8: begin
                // one dominant channel, the others small
                case ($urandom_range(0, 2))
                    0:       push_pixel(m, $urandom_range(0, 7), $urandom_range(0, 7));
                    1:       push_pixel($urandom_range(0, 7), m, $urandom_range(0, 7));
                    default: push_pixel($urandom_range(0, 7), $urandom_range(0, 7), m);
                endcase
            end
            9:       push_pixel(0, $urandom_range(0, 255), $urandom_range(0, 255));
            default: push_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                                $urandom_range(0, 255));
        endcase
    endtask

    // Everything sent and every result back
    task automatic wait_drained();
        while (pending_pixels.size() != 0 || i_valid || expected_hsv_q.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int chunk;
        int n;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pixels: extremes, every sector, ties and the wrap
        push_pixel(0, 0, 0);         // black
        push_pixel(255, 255, 255);   // white
        push_pixel(128, 128, 128);   // mid grey
        push_pixel(255, 0, 0);       // pure red
        push_pixel(0, 255, 0);       // pure green
        push_pixel(0, 0, 255);       // pure blue
        push_pixel(255, 255, 0);     // red/green tie, red wins
        push_pixel(0, 255, 255);     // green/blue tie, green wins
        push_pixel(255, 0, 255);     // red/blue tie, red wins
        push_pixel(255, 0, 1);       // red sector, negative hue wraps
        push_pixel(255, 254, 255);   // red wins tie, negative quotient of a full sextant
        push_pixel(255, 1, 0);       // red sector, small positive hue
        push_pixel(1, 0, 0);         // smallest nonzero max
        push_pixel(0, 0, 1);
        push_pixel(0, 1, 0);
        push_pixel(255, 254, 254);   // smallest delta at full brightness
        push_pixel(254, 255, 0);     // green sector near red
        push_pixel(0, 254, 255);     // blue sector near green
        push_pixel(255, 128, 0);
        push_pixel(85, 170, 255);
        push_pixel(200, 100, 150);   // red sector, negative floor
        push_pixel(100, 200, 150);   // green sector, positive quotient
        push_pixel(150, 100, 200);   // blue sector
        wait_drained();

        // Pressure: hold the output for a long time while pixels keep coming
        tx_burst = 1'b1;
        rx_burst = 1'b1;
        long_hold_req = 1'b1;
        for (n = 0; n < 120; n++) push_random_pixel();
        wait_drained();

        // Random part, alternating idle patterns per chunk
        for (chunk = 0; chunk < 6; chunk++) begin
            tx_burst = (chunk == 1) || (chunk == 3);
            rx_burst = (chunk == 2) || (chunk == 3);
            for (n = 0; n < 97; n++) push_random_pixel();
            while (pending_pixels.size() != 0) @(posedge i_clk);
        end

        wait_drained();
        // keep running idle to catch anything spurious
        repeat (40) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #8000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
